// File: rtl/core/rrap_pkg.sv
// Package for the round-robin address pool: operation and status codes,
// controller state type and the command/status structs between controller and datapath.
// No dependencies.
package rrap_pkg;

  // Default number of table entries
  localparam int POOL_DEPTH_DEF = 16;

  // Field widths fixed by the interface
  localparam int KIND_W = 2;
  localparam int ADDR_W = 16;
  localparam int STAT_W = 3;

  // Requested operation; any other code means get next
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GET    = 2'd2;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_ADDED    = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_FULL     = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_GOT      = 3'd5,
    ST_EMPTY    = 3'd6
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_GET,
    S_GET_WAIT,
    S_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    start;        // latch request, rewind the table walk
    logic    walk_step;    // read next entry of the walk
    logic    walk_wr;      // during a walk, write read data one place down
    logic    shift_start;  // restart walk just past the hit entry
    logic    append;       // write key at end, point at it, bump count
    logic    dec_count;    // drop one entry from the count
    logic    get_rd;       // read entry at the wrapped pointer, advance pointer
    logic    get_cap;      // capture read data as returned address
    logic    set_st;       // record status code st
    status_t st;
    logic    load_out;     // move result into the output register
  } ctl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic in_is_get;  // incoming request is a get
    logic is_add;     // latched request is an add
    logic hit;        // entry under compare matches the key
    logic walk_end;   // walk has covered every valid entry
    logic full;       // table holds POOL_DEPTH entries
    logic empty;      // table holds no entry
    logic out_free;   // output register can take a result
  } dp_sts_t;

endpackage

// File: rtl/core/rrap_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module rrap_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/rrap_ctrl.sv
// Controller FSM for the round-robin address pool: sequences scan, shift and get.
// Depends on rrap_pkg.
module rrap_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rrap_pkg::dp_sts_t  sts,
  output rrap_pkg::ctl_cmd_t cmd
);
  import rrap_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.in_is_get ? S_GET : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          state_nxt = sts.is_add ? S_DONE : S_SHIFT;
        end else if (sts.walk_end) begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: begin
        if (sts.walk_end) begin
          state_nxt = S_DONE;
        end
      end
      S_GET: begin
        state_nxt = sts.empty ? S_DONE : S_GET_WAIT;
      end
      S_GET_WAIT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    cmd.st   = ST_ADDED;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid;
      end
      S_SCAN: begin
        if (sts.hit) begin
          if (sts.is_add) begin
            cmd.set_st = 1'b1;
            cmd.st     = ST_PRESENT;
          end else begin
            cmd.shift_start = 1'b1;
          end
        end else if (sts.walk_end) begin
          cmd.set_st = 1'b1;
          if (!sts.is_add) begin
            cmd.st = ST_NOTFOUND;
          end else if (sts.full) begin
            cmd.st = ST_FULL;
          end else begin
            cmd.append = 1'b1;
            cmd.st     = ST_ADDED;
          end
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts.walk_end) begin
          cmd.dec_count = 1'b1;
          cmd.set_st    = 1'b1;
          cmd.st        = ST_REMOVED;
        end else begin
          cmd.walk_step = 1'b1;
          cmd.walk_wr   = 1'b1;
        end
      end
      S_GET: begin
        if (sts.empty) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_EMPTY;
        end else begin
          cmd.get_rd = 1'b1;
        end
      end
      S_GET_WAIT: begin
        cmd.get_cap = 1'b1;
        cmd.set_st  = 1'b1;
        cmd.st      = ST_GOT;
      end
      S_DONE: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: rtl/core/rrap_dp.sv
// Datapath of the round-robin address pool: entry table RAM, count, pointer,
// table walk and output register. Depends on rrap_pkg and rrap_ram.
module rrap_dp #(
  parameter int POOL_DEPTH = rrap_pkg::POOL_DEPTH_DEF,
  localparam int CNT_W = $clog2(POOL_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [rrap_pkg::KIND_W-1:0] in_kind,
  input  logic [rrap_pkg::ADDR_W-1:0] in_address,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rrap_pkg::ADDR_W-1:0] out_address_out,
  output logic [rrap_pkg::STAT_W-1:0] out_status,
  output logic [CNT_W-1:0]            out_entry_count,
  input  rrap_pkg::ctl_cmd_t          cmd,
  output rrap_pkg::dp_sts_t           sts
);
  import rrap_pkg::*;

  localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;

  // Request and table state
  logic [KIND_W-1:0] kind_r;
  logic [ADDR_W-1:0] key_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;
  // Table walk: next index to read, and the index whose data sits on rd_data
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              pend_r, pend_nxt;
  logic [IDX_W-1:0]  pend_idx_r, pend_idx_nxt;
  // Result
  logic [ADDR_W-1:0] got_r;
  status_t           st_r;
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_addr_r;
  status_t           out_st_r;
  logic [CNT_W-1:0]  out_cnt_r;

  // RAM ports
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [ADDR_W-1:0] wr_data;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [ADDR_W-1:0] rd_data;

  logic              rd_more;
  logic [IDX_W-1:0]  get_sel;
  logic [CNT_W-1:0]  get_inc;

  rrap_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (POOL_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Walk and pointer helpers
  assign rd_more = (rd_idx_r < count_r);
  assign get_sel = (CNT_W'(ptr_r) >= count_r) ? '0 : ptr_r;
  assign get_inc = CNT_W'(get_sel) + CNT_W'(1);

  // RAM access: walk reads or get read; shift write-down or append
  assign rd_en   = (cmd.walk_step && rd_more) || cmd.get_rd;
  assign rd_addr = cmd.get_rd ? get_sel : rd_idx_r[IDX_W-1:0];
  assign wr_en   = (cmd.walk_step && cmd.walk_wr && pend_r) || cmd.append;
  assign wr_addr = cmd.append ? count_r[IDX_W-1:0] : (pend_idx_r - IDX_W'(1));
  assign wr_data = cmd.append ? key_r : rd_data;

  // Next values of control state
  always_comb begin
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    rd_idx_nxt    = rd_idx_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    out_valid_nxt = out_valid_r;
    if (cmd.start) begin
      rd_idx_nxt = '0;
      pend_nxt   = 1'b0;
    end
    if (cmd.walk_step) begin
      pend_nxt     = rd_more;
      pend_idx_nxt = rd_idx_r[IDX_W-1:0];
      if (rd_more) begin
        rd_idx_nxt = rd_idx_r + CNT_W'(1);
      end
    end
    if (cmd.shift_start) begin
      rd_idx_nxt = CNT_W'(pend_idx_r) + CNT_W'(1);
      pend_nxt   = 1'b0;
    end
    if (cmd.append) begin
      ptr_nxt   = count_r[IDX_W-1:0];
      count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.dec_count) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (cmd.get_rd) begin
      ptr_nxt = (get_inc >= count_r) ? '0 : get_inc[IDX_W-1:0];
    end
    // Output register: drained on handoff, refilled on load
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ptr_r       <= '0;
      rd_idx_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      rd_idx_r    <= rd_idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    if (cmd.start) begin
      kind_r <= in_kind;
      key_r  <= in_address;
      got_r  <= '0;
    end
    if (cmd.get_cap) begin
      got_r <= rd_data;
    end
    if (cmd.set_st) begin
      st_r <= cmd.st;
    end
    if (cmd.load_out) begin
      out_addr_r <= got_r;
      out_st_r   <= st_r;
      out_cnt_r  <= count_r;
    end
  end

  // Status to controller
  always_comb begin
    sts           = '0;
    sts.in_is_get = (in_kind != KIND_ADD) && (in_kind != KIND_REMOVE);
    sts.is_add    = (kind_r == KIND_ADD);
    sts.hit       = pend_r && (rd_data == key_r);
    sts.walk_end  = !pend_r && !rd_more;
    sts.full      = (count_r >= CNT_W'(POOL_DEPTH));
    sts.empty     = (count_r == '0);
    sts.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid       = out_valid_r;
  assign out_address_out = out_addr_r;
  assign out_status      = out_st_r;
  assign out_entry_count = out_cnt_r;

`ifndef SYNTHESIS
  // Count never exceeds the table size
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(POOL_DEPTH))
    else $error("entry count beyond table size");

  // Data under compare always comes from a valid entry
  a_pend_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (CNT_W'(pend_idx_r) < count_r))
    else $error("walk read past valid entries");

  // Append only into a table with room
  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |=> (count_r == $past(count_r) + CNT_W'(1)) && (count_r != '0))
    else $error("append did not grow the table");

  // A result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while stalled");
`endif

endmodule

// File: rtl/core/round_robin_address_pool.sv
// Top level of the round-robin address pool: controller plus datapath.
// Depends on rrap_pkg, rrap_ctrl, rrap_dp (and rrap_ram below it).
//
// Keeps up to POOL_DEPTH distinct 16-bit link addresses in a compact table
// with a count and a round-robin pointer, and gives exactly one result
// transaction per request transaction. One request is processed at a time;
// a new one is taken while the previous result still waits in the output
// register. Add and remove walk the table through the RAM's single read
// port, one entry per cycle; a remove that finds its entry then shifts
// every later entry down one place. Get reads the entry at the pointer.
// The table has no reset clearing; only entries below the count are ever read.
module round_robin_address_pool #(
  parameter int POOL_DEPTH = rrap_pkg::POOL_DEPTH_DEF,
  localparam int CNT_W = $clog2(POOL_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rrap_pkg::KIND_W-1:0] in_kind,
  input  logic [rrap_pkg::ADDR_W-1:0] in_address,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rrap_pkg::ADDR_W-1:0] out_address_out,
  output logic [rrap_pkg::STAT_W-1:0] out_status,
  output logic [CNT_W-1:0]            out_entry_count
);
  import rrap_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // Sequencer
  rrap_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table, walk and result datapath
  rrap_dp #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_kind         (in_kind),
    .in_address      (in_address),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_address_out (out_address_out),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

// File: tb/round_robin_address_pool_tb.sv
// Self-checking testbench for round_robin_address_pool: directed and random
// add/remove/get transactions against an internal predictor of the pool.
// Depends on rrap_pkg and the round_robin_address_pool RTL.
`timescale 1ns / 1ps

module round_robin_address_pool_tb;
  import rrap_pkg::*;

  localparam int POOL_DEPTH  = POOL_DEPTH_DEF;
  localparam int CNT_W       = $clog2(POOL_DEPTH + 1);
  localparam int CYCLE_LIMIT = 250000;
  localparam int HOT_SIZE    = 24;
  localparam int SEG_ITEMS   = 45;
  localparam int RAND_ITEMS  = 900;

  // Unused kind code; the block treats it as get next
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] address;
    int                gap;    // idle cycles after this transaction
    bit                drain;  // hold off until all results are back
  } pool_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    status_t           status;
    logic [CNT_W-1:0]  count;
  } pool_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KIND_W-1:0] in_kind = KIND_ADD;
  logic [ADDR_W-1:0] in_address = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ADDR_W-1:0] out_address_out;
  logic [STAT_W-1:0] out_status;
  logic [CNT_W-1:0] out_entry_count;

  pool_req_t    pending_reqs[$];
  pool_result_t expected_results[$];
  int           error_count = 0;
  int           cycle_count = 0;

  // Predictor state
  logic [ADDR_W-1:0] pool_table [POOL_DEPTH];
  int                pool_count = 0;
  int                pool_ptr = 0;

  round_robin_address_pool #(
    .POOL_DEPTH(POOL_DEPTH)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_address     (in_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_address_out(out_address_out),
    .out_status     (out_status),
    .out_entry_count(out_entry_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Apply one request to the predicted pool and return the expected result
  function automatic pool_result_t pool_apply(input logic [KIND_W-1:0] kind,
                                              input logic [ADDR_W-1:0] addr);
    pool_result_t res;
    int hit;
    res.address = '0;
    res.status  = ST_EMPTY;
    hit = -1;
    for (int i = 0; i < pool_count; i++) begin
      if (hit < 0 && pool_table[i] == addr) hit = i;
    end
    case (kind)
      KIND_ADD: begin
        if (hit >= 0) begin
          res.status = ST_PRESENT;
        end else if (pool_count >= POOL_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          pool_table[pool_count] = addr;
          pool_ptr = pool_count;
          pool_count++;
          res.status = ST_ADDED;
        end
      end
      KIND_REMOVE: begin
        if (hit >= 0) begin
          for (int i = hit; i < pool_count - 1; i++) pool_table[i] = pool_table[i + 1];
          pool_count--;
          res.status = ST_REMOVED;
        end else begin
          res.status = ST_NOTFOUND;
        end
      end
      default: begin
        // get next, also for the spare code
        if (pool_count != 0) begin
          if (pool_ptr >= pool_count) pool_ptr = 0;
          res.address = pool_table[pool_ptr];
          pool_ptr++;
          if (pool_ptr >= pool_count) pool_ptr = 0;
          res.status = ST_GOT;
        end
      end
    endcase
    res.count = pool_count[CNT_W-1:0];
    return res;
  endfunction

  function automatic void queue_request(input logic [KIND_W-1:0] kind,
                                        input logic [ADDR_W-1:0] addr,
                                        input bit quiet);
    pool_req_t req;
    req.kind    = kind;
    req.address = addr;
    req.gap     = quiet ? 0 : $urandom_range(0, 5);
    req.drain   = 1'b0;
    pending_reqs.push_back(req);
  endfunction

  function automatic void queue_drain();
    pool_req_t req;
    req.kind    = KIND_GET;
    req.address = '0;
    req.gap     = 0;
    req.drain   = 1'b1;
    pending_reqs.push_back(req);
  endfunction

  // Stimulus: directed corner cases, then segments of biased random traffic
  initial begin
    logic [ADDR_W-1:0] hot_set [HOT_SIZE];
    int mode;
    int pick;
    bit quiet;
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] addr;

    // empty pool, pointer wrap, spare kind code
    queue_request(KIND_GET, 16'h1234, 1'b0);
    queue_request(KIND_REMOVE, 16'h0000, 1'b0);
    queue_request(KIND_ADD, 16'h0000, 1'b0);
    queue_request(KIND_ADD, 16'hFFFF, 1'b0);
    queue_request(KIND_ADD, 16'h0000, 1'b0);
    queue_request(KIND_GET, 16'hFFFF, 1'b0);
    queue_request(KIND_SPARE, 16'h0000, 1'b0);
    queue_request(KIND_REMOVE, 16'hFFFF, 1'b0);
    // pointer now sits past the count
    queue_request(KIND_GET, 16'h0000, 1'b0);
    // fill to the top, then add to a full pool
    for (int i = 0; i < POOL_DEPTH - 1; i++) queue_request(KIND_ADD, 16'h0001 << i, 1'b1);
    queue_request(KIND_ADD, 16'hFFFF, 1'b0);
    queue_request(KIND_ADD, 16'h4000, 1'b0);
    // remove head (longest shift) and tail
    queue_request(KIND_REMOVE, 16'h0000, 1'b0);
    queue_request(KIND_REMOVE, 16'h4000, 1'b0);
    queue_request(KIND_GET, 16'hFFFF, 1'b0);
    queue_drain();

    foreach (hot_set[i]) hot_set[i] = ADDR_W'($urandom_range(0, 16'hFFFF));
    mode  = 0;
    quiet = 1'b0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % SEG_ITEMS == 0) begin
        mode  = $urandom_range(0, 2);
        quiet = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) < 3) begin
          foreach (hot_set[i]) hot_set[i] = ADDR_W'($urandom_range(0, 16'hFFFF));
        end
      end
      if (n % 150 == 149) queue_drain();
      // mode 0 fills, mode 1 drains, mode 2 mixes
      pick = $urandom_range(0, 99);
      case (mode)
        0:       kind = (pick < 65) ? KIND_ADD : (pick < 80) ? KIND_REMOVE : KIND_GET;
        1:       kind = (pick < 15) ? KIND_ADD : (pick < 70) ? KIND_REMOVE : KIND_GET;
        default: kind = (pick < 35) ? KIND_ADD : (pick < 65) ? KIND_REMOVE : KIND_GET;
      endcase
      if (kind == KIND_GET && $urandom_range(0, 4) == 0) kind = KIND_SPARE;
      if ($urandom_range(0, 99) < 85) addr = hot_set[$urandom_range(0, HOT_SIZE - 1)];
      else addr = ADDR_W'($urandom_range(0, 16'hFFFF));
      queue_request(kind, addr, quiet);
    end
  end

  // Driver: presents queued transactions, predicts each one on acceptance
  int idle_left = 0;
  int cur_gap = 0;
  always @(posedge clk) begin
    pool_req_t nxt;
    logic next_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
      idle_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(pool_apply(in_kind, in_address));
        idle_left = cur_gap;
      end
      // a stalled transaction is held as it is
      if (!(in_valid && in_stall)) begin
        next_valid = 1'b0;
        if (idle_left > 0) begin
          idle_left--;
        end else if (pending_reqs.size() != 0) begin
          if (pending_reqs[0].drain) begin
            if (expected_results.size() == 0) void'(pending_reqs.pop_front());
          end else begin
            nxt = pending_reqs.pop_front();
            in_kind    <= nxt.kind;
            in_address <= nxt.address;
            cur_gap    = nxt.gap;
            next_valid = 1'b1;
          end
        end
        in_valid <= next_valid;
      end
    end
  end

  // Monitor: random back-pressure, compares each result with the oldest prediction
  int  hold_left = 0;
  bit  calm = 1'b0;
  always @(posedge clk) begin
    pool_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: address_out %h status %0d entry_count %0d",
                 out_address_out, out_status, out_entry_count);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_address_out !== want.address) begin
            $error("address_out: expected %h, actual %h", want.address, out_address_out);
            error_count++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d (%s), actual %0d", want.status,
                   want.status.name(), out_status);
            error_count++;
          end
          if (out_entry_count !== want.count) begin
            $error("entry_count: expected %0d, actual %0d", want.count, out_entry_count);
            error_count++;
          end
        end
        hold_left = calm ? 0 : $urandom_range(0, 5);
        out_stall <= (hold_left != 0);
      end else if (out_valid && hold_left > 0) begin
        hold_left--;
        out_stall <= (hold_left != 0);
      end
      // switch between stretches with and without back-pressure
      if ($urandom_range(0, 63) == 0) calm = ~calm;
    end
  end

  // Timeout
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // Reset, then wait for all traffic to finish
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/rrap_pkg.sv
rtl/core/rrap_ram.sv
rtl/core/rrap_ctrl.sv
rtl/core/rrap_dp.sv
rtl/core/round_robin_address_pool.sv
tb/round_robin_address_pool_tb.sv
